@@ rtl/text_console_writer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define TCW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console check failed: same-cycle implication");

// Next-cycle implication, checked also across reset
`define TCW_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("console check failed: next-cycle implication");

`endif

@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Geometry, character codes, beat types and state encodings.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_SPACES = 5;
   localparam int CELLS      = COLUMNS * ROWS;

   // Field widths
   localparam int CHAR_W  = 8;
   localparam int IDX_W   = 11;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int POS_W   = 11;
   localparam int COLOR_W = 4;
   localparam int CELL_W  = 2 * COLOR_W + CHAR_W;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int TAB_W   = $clog2(TAB_SPACES + 1);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Control register port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 2'd1;
   localparam logic [COLOR_W-1:0]   FG_RESET     = 4'd7;
   localparam logic [COLOR_W-1:0]   BG_RESET     = 4'd0;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BACK    = 8'h1B;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

   // Operation codes of the input beat
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [POS_W-1:0]  write_pos;
      logic [CELL_W-1:0] cell_data;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_READ,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_TAB,
      CMD_BACK,
      CMD_PLAIN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_addr;
      logic              in_range;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_TAB,
      ST_SCROLL,
      ST_CLRROW
   } back_state_type;

endpackage

@@ rtl/tcw_front.sv @@
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts request beats, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module tcw_front
   import tcw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req_item,
   input  logic             initializing,
   input  queue_status_type q_status,
   output logic             busy,
   output logic             push,
   output cmd_type          push_cmd
);

   logic    valid_ff;
   logic    valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    accept;

   // Hold off new beats in reset, while clearing, and while the held command cannot move on
   assign busy     = reset | initializing | (valid_ff & q_status.full);
   assign accept   = start & ~busy;
   assign push     = valid_ff & ~q_status.full;
   assign push_cmd = cmd_ff;
   assign valid_in = accept | (valid_ff & q_status.full);

   // Classify the request
   always_comb begin
      cmd_in.char_code = req_item.char_code;
      cmd_in.cell_addr = req_item.cell_index[ADDR_W-1:0];
      cmd_in.in_range  = (req_item.cell_index < IDX_W'(CELLS));
      if (req_item.opcode == OP_READ) begin
         cmd_in.kind = CMD_READ;
      end else begin
         unique case (req_item.char_code)
            CH_NEWLINE: cmd_in.kind = CMD_NEWLINE;
            CH_RETURN:  cmd_in.kind = CMD_RETURN;
            CH_TAB:     cmd_in.kind = CMD_TAB;
            CH_BACK:    cmd_in.kind = CMD_BACK;
            default:    cmd_in.kind = CMD_PLAIN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

@@ rtl/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tcw_queue
   import tcw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output queue_status_type q_status,
   output cmd_type          head
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_in;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign head           = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/tcw_back.sv @@
// ----------------------------------------------------------------------------
// Text console writer back end
// Owns the screen memory and cursor state, executes queued commands.
// ----------------------------------------------------------------------------
module tcw_back
   import tcw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            head,
   input  logic               head_valid,
   input  logic [COLOR_W-1:0] fg_color,
   input  logic [COLOR_W-1:0] bg_color,
   output logic               pop,
   output logic               initializing,
   output logic               rsp_strobe,
   output rsp_type            rsp_item
);

   // Screen memory
   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   // Control and cursor state
   back_state_type    state_ff;
   back_state_type    state_in;
   logic [POS_W-1:0]  wpos_ff;
   logic [POS_W-1:0]  wpos_in;
   logic [POS_W-1:0]  rowbase_ff;
   logic [POS_W-1:0]  rowbase_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [POS_W-1:0]  ptr_ff;
   logic [POS_W-1:0]  ptr_in;
   logic [TAB_W-1:0]  tab_cnt_ff;
   logic [TAB_W-1:0]  tab_cnt_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CELL_W-1:0] data_ff;
   logic [CELL_W-1:0] data_in;

   // Shared put path
   logic              put_en;
   logic [CHAR_W-1:0] put_char;
   logic              room;
   logic [COL_W-1:0]  col_next;
   logic [COL_W-1:0]  col_prev;
   logic [POS_W-1:0]  wpos_prev;

   assign initializing = (state_ff == ST_INIT);
   assign rsp_strobe   = rsp_valid_ff;

   assign rsp_item.cursor_row = row_ff;
   assign rsp_item.cursor_col = col_ff;
   assign rsp_item.write_pos  = wpos_ff;
   assign rsp_item.cell_data  = data_ff;

   assign room      = (wpos_ff < POS_W'(CELLS));
   assign col_next  = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + 1'b1;
   assign col_prev  = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - 1'b1;
   assign wpos_prev = (wpos_ff == '0) ? '0 : wpos_ff - 1'b1;

   // Sequence commands
   always_comb begin
      state_in     = state_ff;
      wpos_in      = wpos_ff;
      rowbase_in   = rowbase_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      ptr_in       = ptr_ff;
      tab_cnt_in   = tab_cnt_ff;
      rsp_valid_in = 1'b0;
      data_in      = data_ff;
      pop          = 1'b0;
      put_en       = 1'b0;
      put_char     = CH_SPACE;
      mem_we       = 1'b0;
      mem_waddr    = wpos_ff[ADDR_W-1:0];
      mem_wdata    = {bg_color, fg_color, CH_SPACE};
      mem_raddr    = '0;

      unique case (state_ff)
         // Clear every cell after reset
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[ADDR_W-1:0];
            mem_wdata = '0;
            if (ptr_ff == POS_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               data_in = '0;
               unique case (head.kind)
                  CMD_READ: begin
                     if (head.in_range) begin
                        mem_raddr = head.cell_addr;
                        state_in  = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_NEWLINE: begin
                     col_in = '0;
                     if (row_ff != ROW_W'(ROWS - 1)) begin
                        row_in       = row_ff + 1'b1;
                        rowbase_in   = rowbase_ff + POS_W'(COLUMNS);
                        wpos_in      = rowbase_ff + POS_W'(COLUMNS);
                        rsp_valid_in = 1'b1;
                     end else begin
                        wpos_in  = POS_W'(CELLS - COLUMNS);
                        ptr_in   = '0;
                        state_in = ST_SCROLL;
                     end
                  end
                  CMD_RETURN: begin
                     wpos_in      = rowbase_ff;
                     col_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_TAB: begin
                     tab_cnt_in = '0;
                     state_in   = ST_TAB;
                  end
                  CMD_BACK: begin
                     wpos_in      = wpos_prev;
                     col_in       = (wpos_ff == '0) ? '0 : col_prev;
                     mem_we       = 1'b1;
                     mem_waddr    = wpos_prev[ADDR_W-1:0];
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     put_en       = 1'b1;
                     put_char     = head.char_code;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // Return the cell read in the previous cycle
         ST_READ: begin
            data_in      = rdata_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         // Put one space per cycle
         ST_TAB: begin
            put_en = 1'b1;
            if (tab_cnt_ff == TAB_W'(TAB_SPACES - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               tab_cnt_in = tab_cnt_ff + 1'b1;
            end
         end

         // Copy each cell up one row: read ahead, write the cell behind
         ST_SCROLL: begin
            if (ptr_ff < POS_W'(CELLS - COLUMNS)) begin
               mem_raddr = ADDR_W'(ptr_ff + POS_W'(COLUMNS));
            end
            if (ptr_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(ptr_ff - 1'b1);
               mem_wdata = rdata_ff;
            end
            if (ptr_ff == POS_W'(CELLS - COLUMNS)) begin
               state_in = ST_CLRROW;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // Blank the bottom row
         ST_CLRROW: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[ADDR_W-1:0];
            mem_wdata = '0;
            if (ptr_ff == POS_W'(CELLS - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write at the cursor and advance, dropped when the screen is full
      if (put_en && room) begin
         mem_we    = 1'b1;
         mem_waddr = wpos_ff[ADDR_W-1:0];
         mem_wdata = {bg_color, fg_color, put_char};
         wpos_in   = wpos_ff + 1'b1;
         col_in    = col_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         wpos_ff      <= '0;
         rowbase_ff   <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         tab_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         rowbase_ff   <= rowbase_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         tab_cnt_ff   <= tab_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

endmodule

@@ rtl/text_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// Text console writer top level
// 80x25 character screen with cursor, scrolling and cell readback.
// ----------------------------------------------------------------------------
//   Channel  Ports                               Beat taken when
//   request  start, busy, req_item               start && !busy
//   result   rsp_strobe, rsp_item                rsp_strobe (one cycle)
//   control  csr_valid, csr_ready, csr_index,    csr_valid && csr_ready
//            csr_wdata
//
// A put, return, backspace or newline without scroll is done by the executer
// in its idle state; a read passes through the read state, and a tab puts five
// spaces in the tab state. A newline on the last row copies the screen through
// the single memory port one cell per cycle and then blanks the bottom row.
// After reset the memory is cleared one cell per cycle, and busy
// stays high meanwhile. Busy also rises when the command queue and the front
// register are both full. Results are not held off by the receiver.
module text_console_writer_top
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata
);

   logic [COLOR_W-1:0] fg_ff;
   logic [COLOR_W-1:0] bg_ff;
   logic               initializing;
   logic               push;
   cmd_type            push_cmd;
   logic               pop;
   cmd_type            head;
   queue_status_type   q_status;

   assign csr_ready = ~reset;

   // Color registers; drop writes to unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_ff <= csr_wdata;
            CSR_BG_COLOR: bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tcw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_item     (req_item),
      .initializing (initializing),
      .q_status     (q_status),
      .busy         (busy),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head     (head)
   );

   tcw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (q_status.valid),
      .fg_color     (fg_ff),
      .bg_color     (bg_ff),
      .pop          (pop),
      .initializing (initializing),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item)
   );

endmodule

@@ rtl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// Text console writer port checker
// Watches the top level ports for cursor ranges and reset behavior.
// ----------------------------------------------------------------------------
`include "text_console_writer_top_macros.svh"

module tcw_checker
   import tcw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   logic col_ok;
   logic row_ok;
   logic pos_ok;

   assign col_ok = (rsp_item.cursor_col < COL_W'(COLUMNS));
   assign row_ok = (rsp_item.cursor_row < ROW_W'(ROWS));
   assign pos_ok = (rsp_item.write_pos <= POS_W'(CELLS));

   // Cursor row and column stay on the screen, write position at most one past the last cell
   `TCW_ASSERT_IMPLY(a_col_range, clock, reset, rsp_strobe, col_ok)
   `TCW_ASSERT_IMPLY(a_row_range, clock, reset, rsp_strobe, row_ok)
   `TCW_ASSERT_IMPLY(a_pos_range, clock, reset, rsp_strobe, pos_ok)

   // Reset drops results and starts the clearing pass
   `TCW_ASSERT_NEXT(a_reset_quiet, clock, reset, (busy && !rsp_strobe))

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);
